// ===== hw/rtl/plb_pkg.sv =====
// ----------------------------------------------------------------------------
// plb_pkg: shared definitions for the price level book
// Field widths, reset constants, register map and compare result type.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int PRICE_W        = 32;
  localparam int VOL_W          = 32;
  localparam int LEVELS_W       = 5;
  localparam int DEPTH_W        = 5;
  localparam int MAX_LEVELS_DEF = 16;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(16);

  localparam logic signed [PRICE_W-1:0] INT_MIN = {1'b1, {(PRICE_W-1){1'b0}}};
  localparam logic signed [PRICE_W-1:0] INT_MAX = {1'b0, {(PRICE_W-1){1'b1}}};

  // register index, taken from paddr above the byte offset
  typedef enum logic [0:0] {
    REG_DEPTH = 1'b0
  } plb_reg_t;

  // outcome of the shared signed compare: a against b
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } plb_cmp_t;

endpackage

// ===== hw/rtl/plb_req_if.sv =====
// ----------------------------------------------------------------------------
// plb_req_if: quote request channel
// Valid/ready channel carrying side, price and volume of one quote.
// ----------------------------------------------------------------------------
interface plb_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [plb_pkg::PRICE_W-1:0] price;
  logic        [plb_pkg::VOL_W-1:0]   volume;

  modport source (output valid, cmd, price, volume, input ready);
  modport sink   (input valid, cmd, price, volume, output ready);
endinterface

// ===== hw/rtl/plb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plb_rsp_if: book result channel
// Valid/ready channel carrying the insert flag, best levels and level counts.
// ----------------------------------------------------------------------------
interface plb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                inserted;
  logic signed [plb_pkg::PRICE_W-1:0]  best_bid_price;
  logic        [plb_pkg::VOL_W-1:0]    best_bid_volume;
  logic signed [plb_pkg::PRICE_W-1:0]  best_ask_price;
  logic        [plb_pkg::VOL_W-1:0]    best_ask_volume;
  logic        [plb_pkg::LEVELS_W-1:0] bid_levels;
  logic        [plb_pkg::LEVELS_W-1:0] ask_levels;

  modport source (output valid, inserted, best_bid_price, best_bid_volume,
                  best_ask_price, best_ask_volume, bid_levels, ask_levels,
                  input ready);
  modport sink   (input valid, inserted, best_bid_price, best_bid_volume,
                  best_ask_price, best_ask_volume, bid_levels, ask_levels,
                  output ready);
endinterface

// ===== hw/rtl/price_level_book_top.sv =====
// ----------------------------------------------------------------------------
// price_level_book_top: depth-limited top-of-book keeper
// Files quotes into per-side sorted price level tables held in one memory and
// tracks the best bid and best ask.
// ----------------------------------------------------------------------------
//
//  channel | kind            | carries
//  --------+-----------------+-------------------------------------------------
//  req     | valid/ready in  | cmd (0 ask, 1 bid), price, volume
//  rsp     | valid/ready out | inserted, best bid/ask price and volume, counts
//  apb     | APB write/read  | depth register at byte address 0
//
//  A request is accepted in S_IDLE, walked in S_WALK and placed in S_PLACE;
//  the walk reads one level per cycle from the best end, over the held count
//  (at most MAX_LEVELS), or less when the price is already held.
//  Reset empties both tables, restores the best entries and sets depth to 16.
//  A result waiting on rsp holds the block in its placing cycle; the request
//  side stays ready while the block is idle, even if a result is pending.
// ----------------------------------------------------------------------------
module price_level_book_top #(
  parameter int MAX_LEVELS = plb_pkg::MAX_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  plb_req_if.sink                       req,
  plb_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plb_pkg::PADDR_W-1:0]   paddr,
  input  logic [plb_pkg::PDATA_W-1:0]   pwdata,
  output logic [plb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import plb_pkg::*;

  // count width holds MAX_LEVELS itself; index width addresses one side
  localparam int CW        = $clog2(MAX_LEVELS + 1);
  localparam int AW        = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int MEM_DEPTH = 2 ** (AW + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEVELS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_PLACE = 3'b100
  } state_t;

  state_t state;

  // configuration
  logic [DEPTH_W-1:0] depth;
  logic [CW-1:0]      lim;

  // request held for the walk
  logic                      side;
  logic signed [PRICE_W-1:0] price_q;
  logic [VOL_W-1:0]          vol_q;
  logic [CW-1:0]             n_q;
  logic [CW-1:0]             k;
  logic [CW-1:0]             pos;
  logic                      dup;
  logic                      found;
  logic signed [PRICE_W-1:0] carry;

  // book state
  logic [CW-1:0]             bid_count, ask_count;
  logic [CW-1:0]             bid_count_next, ask_count_next;
  logic signed [PRICE_W-1:0] top_bid_price, top_ask_price;
  logic [VOL_W-1:0]          top_bid_volume, top_ask_volume;
  logic signed [PRICE_W-1:0] top_bid_price_next, top_ask_price_next;
  logic [VOL_W-1:0]          top_bid_volume_next, top_ask_volume_next;

  // level memory: bids descending, asks ascending, so the worst level is last
  logic [PRICE_W-1:0] mem [MEM_DEPTH];
  logic [AW:0]        rd_addr;
  logic [AW:0]        wr_addr;
  logic [PRICE_W-1:0] wr_data;
  logic               mem_we;
  logic [PRICE_W-1:0] rd_data;

  // result register
  logic                      out_valid;
  logic                      out_inserted;
  logic signed [PRICE_W-1:0] out_bid_price, out_ask_price;
  logic [VOL_W-1:0]          out_bid_volume, out_ask_volume;
  logic [LEVELS_W-1:0]       out_bid_levels, out_ask_levels;

  // shared compare unit
  logic signed [PRICE_W-1:0] cmp_b;
  plb_cmp_t                  cmp_res;
  logic                      better;
  logic                      req_fire;
  logic                      place_go;
  logic [CW-1:0]             req_n;
  logic                      ins;
  logic                      best_upd;
  logic [CW-1:0]             count_new;

  plb_cmp u_cmp (
    .a   (price_q),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= DEPTH_RESET;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_DEPTH)) begin
      depth <= pwdata[DEPTH_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_DEPTH: prdata = PDATA_W'(depth);
      default:   prdata = '0;
    endcase
  end

  // clamp depth to the table size
  always_comb begin
    if (int'(depth) > MAX_LEVELS) begin
      lim = MAX_CNT;
    end else begin
      lim = CW'(depth);
    end
  end

  // ---------------------------------------------------------------- compare
  // walk compares against the level just read, placing against the best
  assign cmp_b  = (state == S_WALK) ? $signed(rd_data)
                                    : (side ? top_bid_price : top_ask_price);
  // a bid is better when higher, an ask when lower
  assign better = side ? cmp_res.gt : cmp_res.lt;

  // ---------------------------------------------------------------- handshake
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign place_go  = (state == S_PLACE) && (!out_valid || rsp.ready);
  assign req_n     = req.cmd ? bid_count : ask_count;

  // ---------------------------------------------------------------- memory
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = {side, AW'(n_q)};
    wr_data = carry;
    rd_addr = {side, AW'(k + CW'(1))};
    unique case (state)
      S_IDLE: begin
        rd_addr = {req.cmd, {AW{1'b0}}};
      end
      S_WALK: begin
        // once the slot is found, write the carried level and take the next
        wr_addr = {side, AW'(k)};
        mem_we  = found || (!cmp_res.eq && better);
      end
      S_PLACE: begin
        // the last carried level lands past the held count; a full table has
        // no room for it
        mem_we = place_go && !dup && (n_q != MAX_CNT);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- placing
  always_comb begin
    count_new = n_q;
    ins       = 1'b0;
    if (!dup) begin
      if (n_q >= lim) begin
        // overflow: the worst level drops, which may be the new one
        ins = (pos != n_q);
      end else begin
        count_new = n_q + CW'(1);
        ins       = 1'b1;
      end
    end

    bid_count_next = bid_count;
    ask_count_next = ask_count;
    if (side) begin
      bid_count_next = count_new;
    end else begin
      ask_count_next = count_new;
    end

    best_upd = (vol_q != '0) &&
               (((side ? top_bid_volume : top_ask_volume) == '0) || better);

    top_bid_price_next  = top_bid_price;
    top_bid_volume_next = top_bid_volume;
    top_ask_price_next  = top_ask_price;
    top_ask_volume_next = top_ask_volume;
    if (best_upd && side) begin
      top_bid_price_next  = price_q;
      top_bid_volume_next = vol_q;
    end
    if (best_upd && !side) begin
      top_ask_price_next  = price_q;
      top_ask_volume_next = vol_q;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bid_count      <= '0;
      ask_count      <= '0;
      top_bid_price  <= INT_MIN;
      top_bid_volume <= '0;
      top_ask_price  <= INT_MAX;
      top_ask_volume <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !place_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            // empty side: place at the head at once
            state <= (req_n == '0) ? S_PLACE : S_WALK;
          end
        end
        S_WALK: begin
          if ((!found && cmp_res.eq) || (k == n_q - CW'(1))) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (place_go) begin
            state          <= S_IDLE;
            bid_count      <= bid_count_next;
            ask_count      <= ask_count_next;
            top_bid_price  <= top_bid_price_next;
            top_bid_volume <= top_bid_volume_next;
            top_ask_price  <= top_ask_price_next;
            top_ask_volume <= top_ask_volume_next;
            out_valid      <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          side    <= req.cmd;
          price_q <= req.price;
          vol_q   <= req.volume;
          n_q     <= req_n;
          k       <= '0;
          pos     <= req_n;
          dup     <= 1'b0;
          found   <= 1'b0;
          carry   <= req.price;
        end
      end
      S_WALK: begin
        if (!found && cmp_res.eq) begin
          // price already held: leave the table alone
          dup <= 1'b1;
        end else begin
          if (!found && better) begin
            found <= 1'b1;
            pos   <= k;
          end
          if (found || better) begin
            carry <= rd_data;
          end
          k <= k + CW'(1);
        end
      end
      S_PLACE: begin
        if (place_go) begin
          out_inserted   <= ins;
          out_bid_price  <= top_bid_price_next;
          out_bid_volume <= top_bid_volume_next;
          out_ask_price  <= top_ask_price_next;
          out_ask_volume <= top_ask_volume_next;
          out_bid_levels <= LEVELS_W'(bid_count_next);
          out_ask_levels <= LEVELS_W'(ask_count_next);
        end
      end
      default: begin
        dup <= dup;
      end
    endcase
  end

  assign rsp.valid           = out_valid;
  assign rsp.inserted        = out_inserted;
  assign rsp.best_bid_price  = out_bid_price;
  assign rsp.best_bid_volume = out_bid_volume;
  assign rsp.best_ask_price  = out_ask_price;
  assign rsp.best_ask_volume = out_ask_volume;
  assign rsp.bid_levels      = out_bid_levels;
  assign rsp.ask_levels      = out_ask_levels;

endmodule

// ===== hw/rtl/plb_cmp.sv =====
// ----------------------------------------------------------------------------
// plb_cmp: shared signed price comparator
// One 32-bit signed compare, reused for the level walk and the best update.
// ----------------------------------------------------------------------------
module plb_cmp (
  input  logic signed [plb_pkg::PRICE_W-1:0] a,
  input  logic signed [plb_pkg::PRICE_W-1:0] b,
  output plb_pkg::plb_cmp_t                  res
);
  import plb_pkg::*;

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule

// ===== hw/rtl/plb_checker.sv =====
// ----------------------------------------------------------------------------
// plb_checker: port-level checks for the price level book
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module plb_checker #(
  parameter int MAX_LEVELS = plb_pkg::MAX_LEVELS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic                               rsp_inserted,
  input logic signed [plb_pkg::PRICE_W-1:0] best_bid_price,
  input logic [plb_pkg::VOL_W-1:0]          best_bid_volume,
  input logic signed [plb_pkg::PRICE_W-1:0] best_ask_price,
  input logic [plb_pkg::VOL_W-1:0]          best_ask_volume,
  input logic [plb_pkg::LEVELS_W-1:0]       bid_levels,
  input logic [plb_pkg::LEVELS_W-1:0]       ask_levels
);
  import plb_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inserted) &&
      $stable(best_bid_price) && $stable(best_ask_price) &&
      $stable(bid_levels) && $stable(ask_levels))
    else $error("result changed while stalled");

  // busy after each accepted request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a walk is running");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

  // counts never pass the table size
  a_levels: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(bid_levels) <= MAX_LEVELS) && (int'(ask_levels) <= MAX_LEVELS))
    else $error("level count beyond table size");

  // an empty best still shows its reset price
  a_empty_best: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((best_bid_volume != '0) || (best_bid_price == INT_MIN)) &&
                  ((best_ask_volume != '0) || (best_ask_price == INT_MAX)))
    else $error("empty best side shows a moved price");

endmodule

bind price_level_book_top plb_checker #(.MAX_LEVELS(MAX_LEVELS)) u_plb_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_inserted    (rsp.inserted),
  .best_bid_price  (rsp.best_bid_price),
  .best_bid_volume (rsp.best_bid_volume),
  .best_ask_price  (rsp.best_ask_price),
  .best_ask_volume (rsp.best_ask_volume),
  .bid_levels      (rsp.bid_levels),
  .ask_levels      (rsp.ask_levels)
);
